FILE: rtl/hgrs_pkg.sv
// Shared types and constants for the hex grid range search block.
// No dependencies; imported by hgrs_cell, hex_grid_range_search_top and the testbench.
package hgrs_pkg;

    localparam int CENTER_W = 8;
    localparam int RADIUS_W = 3;
    localparam int TILE_W   = 8;

    typedef struct packed {
        logic load;
        logic grow;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_GROW  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

FILE: rtl/hgrs_cell.sv
// One map column of the hex grid range search: holds the column's reached bits,
// seeds from the center, dilates from its neighbors and shifts left for the scan.
// Depends on hgrs_pkg.
module hgrs_cell
    import hgrs_pkg::*;
#(
    parameter int MAP_WIDTH  = 16,
    parameter int MAP_HEIGHT = 16,
    parameter int COL        = 0,
    parameter int IDX_W      = 8
) (
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [CENTER_W-1:0]   center,
    input  logic [MAP_HEIGHT-1:0] left_col,
    input  logic [MAP_HEIGHT-1:0] right_col,
    output logic [MAP_HEIGHT-1:0] col
);

    localparam bit ODD_COL = ((COL % 2) == 1);

    logic [MAP_HEIGHT-1:0] col_reg;
    logic [MAP_HEIGHT-1:0] col_next;
    logic [MAP_HEIGHT-1:0] seed;
    logic [MAP_HEIGHT-1:0] side;
    logic [MAP_HEIGHT-1:0] side_grow;
    logic [MAP_HEIGHT-1:0] own_grow;

    always_comb begin
        for (int y = 0; y < MAP_HEIGHT; y++) begin
            seed[y] = (IDX_W'(y * MAP_WIDTH + COL) == IDX_W'(center));
        end
    end

    assign side     = left_col | right_col;
    assign own_grow = col_reg | {col_reg[MAP_HEIGHT-2:0], 1'b0} | {1'b0, col_reg[MAP_HEIGHT-1:1]};

    generate
        if (ODD_COL) begin : g_odd
            assign side_grow = side | {1'b0, side[MAP_HEIGHT-1:1]};
        end else begin : g_even
            assign side_grow = side | {side[MAP_HEIGHT-2:0], 1'b0};
        end
    endgenerate

    always_comb begin
        col_next = col_reg;
        priority if (ctrl.load) begin
            col_next = seed;
        end else if (ctrl.grow) begin
            col_next = own_grow | side_grow;
        end else if (ctrl.shift) begin
            col_next = right_col;
        end else begin
            col_next = col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    assign col = col_reg;

endmodule

FILE: rtl/hex_grid_range_search_top.sv
// Top level of the hex grid range search: request control, column cell chain,
// ordered scan and output register. Depends on hgrs_pkg and hgrs_cell.
//
// Usage:
//   s_ channel: one request per transaction, center tile and radius.
//   m_ channel: one transaction per reached tile other than the center, in
//   ascending column, then row; m_tlast marks the final tile of a request.
//   A radius of 0, or a center outside the map, gives no transactions.
//   A request passes through the accepting idle state, one expansion round per
//   unit of radius (saturated to MAX_RADIUS), a scan start, a scan over all
//   MAP_WIDTH*MAP_HEIGHT tiles and a flush. The scan walks one tile per cycle,
//   unless a stalled receiver holds it, through the leftmost column cell while
//   the chain shifts columns left, which sets the rate. s_tready is high only
//   between requests, low in reset. The first result waits for the second
//   reached tile or the end of the scan, since each tile is first held pending.
//   When the receiver stalls, the scan holds on the next reached tile; the
//   output register keeps its transaction until taken.
//   Reset clears control state and the output register's valid flag.
module hex_grid_range_search_top
    import hgrs_pkg::*;
#(
    parameter int MAP_WIDTH  = 16,
    parameter int MAP_HEIGHT = 16,
    parameter int MAX_RADIUS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] center_tile, [10:8] radius, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tile_index
    output logic        m_tlast
);

    localparam int TILES = MAP_WIDTH * MAP_HEIGHT;
    localparam int LIN_W = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int IDX_W = (LIN_W > TILE_W) ? LIN_W : TILE_W;
    localparam int X_W   = $clog2(MAP_WIDTH);
    localparam int Y_W   = $clog2(MAP_HEIGHT);

    logic [CENTER_W-1:0] s_center;
    logic [RADIUS_W-1:0] s_radius;
    logic [RADIUS_W-1:0] s_radius_sat;

    state_t              state_reg, state_next;
    logic [RADIUS_W-1:0] rounds_reg, rounds_next;
    logic [IDX_W-1:0]    center_reg, center_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [IDX_W-1:0]    lin_reg, lin_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TILE_W-1:0]   pend_tile_reg, pend_tile_next;
    logic                out_valid_reg, out_valid_next;
    logic [TILE_W-1:0]   out_tile_reg, out_tile_next;
    logic                out_last_reg, out_last_next;

    cell_ctrl_t          ctrl;
    logic [MAP_HEIGHT-1:0] col_w [MAP_WIDTH];

    logic s_accept;
    logic out_free;
    logic hit;
    logic step;
    logic col_end;
    logic scan_end;

    assign s_center     = s_tdata[CENTER_W-1:0];
    assign s_radius     = s_tdata[CENTER_W+RADIUS_W-1:CENTER_W];
    assign s_radius_sat = (s_radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : s_radius;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign hit      = col_w[0][y_reg] && (lin_reg != center_reg);
    assign step     = !(hit && pend_valid_reg && !out_free);
    assign col_end  = (y_reg == Y_W'(MAP_HEIGHT - 1));
    assign scan_end = col_end && (x_reg == X_W'(MAP_WIDTH - 1));

    always_comb begin
        state_next      = state_reg;
        rounds_next     = rounds_reg;
        center_next     = center_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        lin_next        = lin_reg;
        pend_valid_next = pend_valid_reg;
        pend_tile_next  = pend_tile_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_tile_next   = out_tile_reg;
        out_last_next   = out_last_reg;
        ctrl            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ctrl.load   = 1'b1;
                    center_next = IDX_W'(s_center);
                    rounds_next = s_radius_sat;
                    state_next  = ST_GROW;
                end
            end
            ST_GROW: begin
                if (rounds_reg != '0) begin
                    ctrl.grow   = 1'b1;
                    rounds_next = rounds_reg - 1'b1;
                end else begin
                    x_next          = '0;
                    y_next          = '0;
                    lin_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_tile_next  = pend_tile_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_tile_next  = lin_reg[TILE_W-1:0];
                    end
                    if (scan_end) begin
                        state_next = ST_FLUSH;
                    end else if (col_end) begin
                        ctrl.shift = 1'b1;
                        y_next     = '0;
                        x_next     = x_reg + 1'b1;
                        lin_next   = IDX_W'(x_reg) + 1'b1;
                    end else begin
                        y_next   = y_reg + 1'b1;
                        lin_next = lin_reg + IDX_W'(MAP_WIDTH);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_tile_next   = pend_tile_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        rounds_reg    <= rounds_next;
        center_reg    <= center_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        lin_reg       <= lin_next;
        pend_tile_reg <= pend_tile_next;
        out_tile_reg  <= out_tile_next;
        out_last_reg  <= out_last_next;
    end

    generate
        for (genvar c = 0; c < MAP_WIDTH; c++) begin : g_col
            logic [MAP_HEIGHT-1:0] left_col;
            logic [MAP_HEIGHT-1:0] right_col;

            if (c == 0) begin : g_left_edge
                assign left_col = '0;
            end else begin : g_left
                assign left_col = col_w[c-1];
            end

            if (c == MAP_WIDTH - 1) begin : g_right_edge
                assign right_col = '0;
            end else begin : g_right
                assign right_col = col_w[c+1];
            end

            hgrs_cell #(
                .MAP_WIDTH  (MAP_WIDTH),
                .MAP_HEIGHT (MAP_HEIGHT),
                .COL        (c),
                .IDX_W      (IDX_W)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .center    (s_center),
                .left_col  (left_col),
                .right_col (right_col),
                .col       (col_w[c])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tile_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for hex_grid_range_search_top: hex range requests in,
// reached tiles checked in scan order against a built-in breadth-first predictor.
// Depends on hgrs_pkg and the RTL of hex_grid_range_search_top.
module testbench
    import hgrs_pkg::*;
();

    localparam int MAP_W     = 16;
    localparam int MAP_H     = 16;
    localparam int MAP_TILES = MAP_W * MAP_H;
    localparam int MAX_RAD   = 4;

    typedef struct {
        logic [TILE_W-1:0] tile;
        logic              last;
    } tile_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    tile_result_t reached_tiles[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_checked = 0;
    int requests_sent  = 0;
    int empty_requests = 0;
    int saturated_requests = 0;

    hex_grid_range_search_top #(
        .MAP_WIDTH (MAP_W),
        .MAP_HEIGHT(MAP_H),
        .MAX_RADIUS(MAX_RAD)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic void queue_tile(input int tile_idx, input logic is_last);
        tile_result_t item;
        item.tile = tile_idx[TILE_W-1:0];
        item.last = is_last;
        reached_tiles.insert(reached_tiles.size(), item);
    endfunction

    // Breadth-first expansion on the column-offset map, then a column-major scan.
    function automatic void predict_reach(input logic [CENTER_W-1:0] center,
                                          input logic [RADIUS_W-1:0] rad);
        bit reached [MAP_TILES];
        int ring [MAP_TILES];
        int rounds, t, nt, nx, ny, dx, dy, prev;
        bit odd;
        rounds = (rad > MAX_RAD) ? MAX_RAD : int'(rad);
        requests_sent++;
        if (rad > MAX_RAD)
            saturated_requests++;
        for (int i = 0; i < MAP_TILES; i++) begin
            reached[i] = 1'b0;
            ring[i] = 0;
        end
        reached[center] = 1'b1;
        for (int r = 0; r < rounds; r++) begin
            for (int y = 0; y < MAP_H; y++) begin
                for (int x = 0; x < MAP_W; x++) begin
                    t = y * MAP_W + x;
                    if (!reached[t] || ring[t] != r)
                        continue;
                    odd = x[0];
                    for (int d = 0; d < 6; d++) begin
                        case (d)
                            0: begin dx = 1;  dy = odd ? 1 : 0;  end
                            1: begin dx = 0;  dy = 1;            end
                            2: begin dx = -1; dy = odd ? 1 : 0;  end
                            3: begin dx = -1; dy = odd ? 0 : -1; end
                            4: begin dx = 0;  dy = -1;           end
                            default: begin dx = 1; dy = odd ? 0 : -1; end
                        endcase
                        nx = x + dx;
                        ny = y + dy;
                        if (nx < 0 || nx >= MAP_W || ny < 0 || ny >= MAP_H)
                            continue;
                        nt = ny * MAP_W + nx;
                        if (!reached[nt]) begin
                            reached[nt] = 1'b1;
                            ring[nt] = r + 1;
                        end
                    end
                end
            end
        end
        prev = -1;
        for (int x = 0; x < MAP_W; x++) begin
            for (int y = 0; y < MAP_H; y++) begin
                t = y * MAP_W + x;
                if (!reached[t] || t == int'(center))
                    continue;
                if (prev >= 0)
                    queue_tile(prev, 1'b0);
                prev = t;
            end
        end
        if (prev >= 0)
            queue_tile(prev, 1'b1);
        else
            empty_requests++;
    endfunction

    // Enter and leave on a falling edge; s_tvalid stays up for a back-to-back request.
    task automatic send_request(input logic [CENTER_W-1:0] center,
                                input logic [RADIUS_W-1:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rad, center};
        do @(posedge aclk); while (!s_tready);
        predict_reach(center, rad);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reached_tiles.size() != 0)
            @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        tile_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reached_tiles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: tile %0d last %0b", m_tdata, m_tlast);
            end else begin
                want = reached_tiles.pop_front();
                results_checked++;
                if (m_tdata !== want.tile || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected tile %0d last %0b, got tile %0d last %0b",
                                 want.tile, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic test_zero_radius();
        send_request(8'd0, 3'd0);
        send_request(8'd255, 3'd0);
        send_request(8'd119, 3'd0);
    endtask

    task automatic test_map_corners();
        send_request(8'd0, 3'd4);
        send_request(8'd15, 3'd4);
        send_request(8'd240, 3'd4);
        send_request(8'd255, 3'd4);
        send_request(8'd0, 3'd1);
        send_request(8'd15, 3'd1);
        send_request(8'd240, 3'd1);
        send_request(8'd255, 3'd1);
    endtask

    task automatic test_radius_saturation();
        send_request(8'd119, 3'd5);
        send_request(8'd136, 3'd6);
        send_request(8'd120, 3'd7);
    endtask

    task automatic test_column_parity();
        send_request(8'h77, 3'd1);
        send_request(8'h78, 3'd1);
        send_request(8'h87, 3'd2);
        send_request(8'h88, 3'd3);
        send_request(8'h7f, 3'd2);
        send_request(8'h80, 3'd3);
    endtask

    task automatic test_random_requests(input int count, input int idle_pct,
                                        input int stall_pct);
        logic [CENTER_W-1:0] center;
        logic [RADIUS_W-1:0] rad;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            center = CENTER_W'($urandom_range(255));
            // pull some centers onto the map border
            case ($urandom_range(5))
                0: center[3:0] = $urandom_range(1) ? 4'd0 : 4'd15;
                1: center[7:4] = $urandom_range(1) ? 4'd0 : 4'd15;
                default: ;
            endcase
            if ($urandom_range(9) == 0)
                rad = RADIUS_W'($urandom_range(7, 5));
            else
                rad = RADIUS_W'($urandom_range(4));
            send_request(center, rad);
        end
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        send_request(8'd34, 3'd4);
        send_request(8'd201, 3'd3);
        wait_drained();
        send_request(8'd170, 3'd2);
        send_request(8'd68, 3'd4);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_zero_radius();
        test_map_corners();
        test_radius_saturation();
        test_column_parity();
        test_random_requests(48, 0, 0);
        test_random_requests(48, 45, 0);
        test_random_requests(48, 0, 45);
        test_pause_until_drained();
        test_random_requests(48, 30, 30);

        wait_drained();
        repeat (300) @(negedge aclk);

        $display("covered %0d requests (%0d reaching no tile, %0d with saturated radius)",
                 requests_sent, empty_requests, saturated_requests);
        $display("checked %0d tile transactions, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("hex_grid_range_search_top regression: pass");
        else
            $display("hex_grid_range_search_top regression: fail");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d tiles outstanding", reached_tiles.size());
        $display("hex_grid_range_search_top regression: fail");
        $finish;
    end

endmodule
